// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the predictor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- src/pbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Perceptron predictor package
// Shared constants and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pbp_pkg;
  localparam int HistoryLength = 32;
  localparam int TableRows = 256;
  localparam int WeightLimit = 127;
  localparam int AddrWidth = 48;
  localparam int SumOutWidth = 14;
  localparam int ThreshWidth = 13;
  localparam logic [ThreshWidth-1:0] ThreshReset = 13'd75;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_WRITE
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic clearing;
  } bk_status_t;
endpackage

// ----- src/pbp_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake channel carrying a packed payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface pbp_if #(parameter int Width = 1);
  logic valid;
  logic ready;
  logic [Width-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- src/perceptron_branch_predictor.sv -----
// Throughput: one weight summed per cycle; the back end takes a new branch only once the last is finished.
// Reset: history cleared, threshold set to 75, then a
// clearing pass zeroes the weight memory, one row per cycle.
// ----------------------------------------------------------------------------
// Perceptron branch predictor
// Global history perceptron predictor with on-line training.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module perceptron_branch_predictor
  import pbp_pkg::*;
#(
  parameter int HISTORY_LENGTH = HistoryLength,
  parameter int TABLE_ROWS = TableRows,
  parameter int WEIGHT_LIMIT = WeightLimit
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [ThreshWidth-1:0] cfg_wdata,
  pbp_if.sink                    req,
  pbp_if.source                  rsp
);
  localparam int RowBits = $clog2(TABLE_ROWS);

  logic [ThreshWidth-1:0] threshold;
  logic [RowBits:0]       q_data;
  logic                   q_valid;
  logic                   q_pop;
  bk_status_t             status;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThreshReset;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  pbp_front #(.RowBits(RowBits)) u_front (
    .clk(clk), .rst(rst),
    .in_addr(req.data[AddrWidth:1]), .in_taken(req.data[0]),
    .in_valid(req.valid), .in_ready(req.ready),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  pbp_back #(
    .HistLen(HISTORY_LENGTH), .Rows(TABLE_ROWS), .WLimit(WEIGHT_LIMIT)
  ) u_back (
    .clk(clk), .rst(rst), .threshold(threshold),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data),
    .status(status)
  );
endmodule

// ----- src/pbp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/pbp_front.sv -----
// ----------------------------------------------------------------------------
// Predictor front end
// Accept branch requests, extract row index, queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pbp_front
  import pbp_pkg::*;
#(
  parameter int RowBits = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [AddrWidth-1:0] in_addr,
  input  logic               in_taken,
  input  logic               in_valid,
  output logic               in_ready,
  output logic [RowBits:0]   q_data,
  output logic               q_valid,
  input  logic               q_pop
);
  logic [RowBits:0] q_mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  logic             push;

  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_data = q_mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp] <= {in_taken, in_addr[RowBits-1:0]};
    end
  end
endmodule

// ----- src/pbp_back.sv -----
// ----------------------------------------------------------------------------
// Predictor back end
// Read a row, form the sum, train, update history and emit the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbp_back
  import pbp_pkg::*;
#(
  parameter int HistLen = HistoryLength,
  parameter int Rows = TableRows,
  parameter int WLimit = WeightLimit
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ThreshWidth-1:0]     threshold,
  input  logic [$clog2(Rows):0]      q_data,
  input  logic                       q_valid,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SumOutWidth+2:0]     out_data,
  output bk_status_t                 status
);
  localparam int RowBits = $clog2(Rows);
  localparam int WBits = $clog2(WLimit + 1) + 1;
  localparam int RowW = WBits * (HistLen + 1);
  localparam int SumW = $clog2((HistLen + 1) * WLimit + 1) + 2;
  localparam int CntW = $clog2(HistLen + 2);
  localparam int HBits = $clog2(HistLen);

  bk_state_t state, state_next;
  logic [RowBits-1:0] row;
  logic               taken;
  logic [HistLen-1:0] hist;
  logic [RowBits-1:0] clr;
  logic               ram_we;
  logic [RowBits-1:0] ram_waddr;
  logic [RowW-1:0]    ram_wdata;
  logic [RowW-1:0]    ram_rdata;
  logic [RowW-1:0]    wrow;
  logic [RowW-1:0]    trow;
  logic [CntW-1:0]    idx;
  logic signed [SumW-1:0] sum;
  logic signed [WBits-1:0] w_cur;
  logic               bit_cur;
  logic               pred;
  logic               train;
  logic [SumW-1:0]    mag;
  logic signed [SumOutWidth-1:0] rep;
  logic               out_full;

  pbp_ram #(.Width(RowW), .Depth(Rows)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(q_data[RowBits-1:0]), .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == RowBits'(Rows - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (q_valid && (!out_full || out_ready)) state_next = ST_READ;
      ST_READ:  state_next = ST_SUM;
      ST_SUM:   if (idx == CntW'(HistLen)) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    q_pop = (state == ST_IDLE) && q_valid && (!out_full || out_ready);
    ram_we = (state == ST_CLEAR) || ((state == ST_WRITE) && train);
    ram_waddr = (state == ST_CLEAR) ? clr : row;
    ram_wdata = (state == ST_CLEAR) ? '0 : trow;
    status.busy = (state != ST_IDLE);
    status.clearing = (state == ST_CLEAR);
  end

  assign w_cur = wrow[idx*WBits +: WBits];
  assign bit_cur = (idx == '0) ? 1'b1 : hist[HBits'(idx - CntW'(1))];
  assign pred = !sum[SumW-1];
  assign mag = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
  assign train = (pred != taken) || (mag <= SumW'(threshold));

  always_comb begin
    if (sum > SumW'(8191)) rep = 14'sd8191;
    else if (sum < -SumW'(8192)) rep = 14'sh2000;
    else rep = sum[SumOutWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      hist <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + RowBits'(1);
      if (out_full && out_ready) out_full <= 1'b0;
      if (state == ST_WRITE) begin
        hist <= {hist[HistLen-2:0], taken};
        out_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      row <= q_data[RowBits-1:0];
      taken <= q_data[RowBits];
    end
    if (state == ST_READ) begin
      wrow <= ram_rdata;
      idx <= '0;
      sum <= '0;
    end
    if (state == ST_SUM) begin
      sum <= bit_cur ? sum + SumW'(w_cur) : sum - SumW'(w_cur);
      if (bit_cur == taken) begin
        trow[idx*WBits +: WBits] <= (w_cur == WBits'(WLimit)) ? w_cur : w_cur + WBits'(1);
      end else begin
        trow[idx*WBits +: WBits] <= (w_cur == -WBits'(WLimit)) ? w_cur : w_cur - WBits'(1);
      end
      idx <= idx + CntW'(1);
    end
    if (state == ST_WRITE) begin
      out_data <= {train, pred == taken, rep, pred};
    end
  end

  assign out_valid = out_full;

  `ASSERT_IMPLIES(a_pop_idle, clk, rst, q_pop, state == ST_IDLE)
  `ASSERT_NEXT(a_write_full, clk, rst, state == ST_WRITE, out_full)
  `ASSERT_IMPLIES(a_no_pop_clear, clk, rst, status.clearing, !q_pop)
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perceptron branch predictor testbench
// Feeds resolved branches through the request channel, models the weight
// table and global history alongside, and compares every response field.
// The run covers several training thresholds, random gaps on both sides,
// a long response back-pressure stretch and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import pbp_pkg::*;

  localparam int ReqWidth = AddrWidth + 1;
  localparam int RspWidth = SumOutWidth + 3;
  localparam int IdleLimit = 3000;
  localparam int DrainCycles = 60;
  localparam int HoldCycles = 300;

  typedef struct {
    logic                   predicted_taken;
    logic [SumOutWidth-1:0] perceptron_sum;
    logic                   prediction_correct;
    logic                   trained;
  } verdict_t;

  typedef struct {
    logic [AddrWidth-1:0] addr;
    logic                 taken;
    logic                 fixed;
    verdict_t             want;
  } branch_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ThreshWidth-1:0] cfg_wdata;

  pbp_if #(.Width(ReqWidth)) req ();
  pbp_if #(.Width(RspWidth)) rsp ();

  perceptron_branch_predictor u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req),
    .rsp(rsp)
  );

  int weights [TableRows][HistoryLength+1];
  logic [HistoryLength-1:0] ghist;
  int threshold;
  verdict_t verdict_q[$];
  int errors;
  int idle_cycles;
  bit hold_rsp;
  bit no_stall;
  int rsp_wait;
  int hold_left;
  branch_row_t directed [];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_weight(int v);
    if (v > WeightLimit) return WeightLimit;
    if (v < -WeightLimit) return -WeightLimit;
    return v;
  endfunction

  function automatic verdict_t predict_branch(logic [AddrWidth-1:0] addr, logic taken);
    verdict_t v;
    int row;
    int sum;
    int mag;
    int rep;
    bit pred;
    bit train;
    row = int'(addr % TableRows);
    sum = weights[row][0];
    for (int i = 0; i < HistoryLength; i++) begin
      if (ghist[i]) sum += weights[row][i+1];
      else sum -= weights[row][i+1];
    end
    pred = (sum >= 0);
    mag = (sum < 0) ? -sum : sum;
    train = (pred != taken) || (mag <= threshold);
    if (train) begin
      weights[row][0] = clamp_weight(weights[row][0] + (taken ? 1 : -1));
      for (int i = 0; i < HistoryLength; i++)
        weights[row][i+1] = clamp_weight(weights[row][i+1] + ((ghist[i] == taken) ? 1 : -1));
    end
    ghist = {ghist[HistoryLength-2:0], taken};
    rep = sum;
    if (rep > 8191) rep = 8191;
    if (rep < -8192) rep = -8192;
    v.predicted_taken = pred;
    v.perceptron_sum = rep[SumOutWidth-1:0];
    v.prediction_correct = (pred == taken);
    v.trained = train;
    return v;
  endfunction

  task automatic send_branch(logic [AddrWidth-1:0] addr, logic taken, bit fixed, verdict_t want);
    int gap;
    verdict_t v;
    gap = no_stall ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= {addr, taken};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    v = predict_branch(addr, taken);
    verdict_q.push_back(fixed ? want : v);
  endtask

  task automatic drain_requests();
    req.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(int value);
    drain_requests();
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[ThreshWidth-1:0];
    threshold = value & 13'h1fff;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_branches(int count);
    logic [AddrWidth-1:0] addr;
    logic taken;
    int mode;
    verdict_t none;
    none = '{default: '0};
    for (int n = 0; n < count; n++) begin
      addr = AddrWidth'({$urandom(), $urandom()});
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        addr[7:0] = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 1))
                                               : 8'($urandom_range(2, 5));
        case (addr[2:0])
          3'd0: taken = 1'b1;
          3'd1: taken = 1'b0;
          3'd2: taken = ~ghist[0];
          3'd3: taken = ghist[1] ^ ghist[4];
          default: taken = 1'($urandom_range(0, 1));
        endcase
        if ($urandom_range(0, 19) == 0) taken = ~taken;
      end else begin
        taken = 1'($urandom_range(0, 1));
      end
      send_branch(addr, taken, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    if (rsp.valid && rsp.ready) begin
      verdict_t got;
      verdict_t exp_v;
      {got.trained, got.prediction_correct, got.perceptron_sum, got.predicted_taken} = rsp.data;
      if (verdict_q.size() == 0) begin
        $display("%0t: response with none pending: %h", $time, rsp.data);
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (got.predicted_taken !== exp_v.predicted_taken) begin
          $display("%0t: predicted_taken exp %0b got %0b", $time,
                   exp_v.predicted_taken, got.predicted_taken);
          errors++;
        end
        if (got.perceptron_sum !== exp_v.perceptron_sum) begin
          $display("%0t: perceptron_sum exp %0d got %0d", $time,
                   $signed(exp_v.perceptron_sum), $signed(got.perceptron_sum));
          errors++;
        end
        if (got.prediction_correct !== exp_v.prediction_correct) begin
          $display("%0t: prediction_correct exp %0b got %0b", $time,
                   exp_v.prediction_correct, got.prediction_correct);
          errors++;
        end
        if (got.trained !== exp_v.trained) begin
          $display("%0t: trained exp %0b got %0b", $time, exp_v.trained, got.trained);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_wait <= 0;
      hold_left <= 0;
    end else if (hold_rsp && hold_left == 0) begin
      hold_left <= HoldCycles;
      rsp.ready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else if (rsp.valid && rsp.ready) begin
      if (hold_left == 1) hold_left <= 0;
      rsp_wait <= no_stall ? 0 : $urandom_range(0, 7);
      rsp.ready <= no_stall;
    end else if (rsp_wait > 0) begin
      rsp_wait <= rsp_wait - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    verdict_t none;
    none = '{default: '0};
    errors = 0;
    hold_rsp = 1'b0;
    no_stall = 1'b0;
    threshold = 75;
    ghist = '0;
    foreach (weights[r, i]) weights[r][i] = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.data = '0;

    directed = new[14];
    directed[0] = '{48'h0, 1'b1, 1'b1, '{1'b1, 14'd0, 1'b1, 1'b1}};
    directed[1] = '{48'hffff_ffff_ffff, 1'b0, 1'b1, '{1'b1, 14'd0, 1'b0, 1'b1}};
    directed[2] = '{48'h0, 1'b1, 1'b0, none};
    directed[3] = '{48'h8000_0000_0000, 1'b0, 1'b0, none};
    directed[4] = '{48'h0000_0000_00ff, 1'b1, 1'b0, none};
    directed[5] = '{48'h5555_5555_5555, 1'b1, 1'b0, none};
    directed[6] = '{48'haaaa_aaaa_aaaa, 1'b0, 1'b0, none};
    directed[7] = '{48'h0000_0000_0100, 1'b1, 1'b0, none};
    directed[8] = '{48'h0, 1'b0, 1'b0, none};
    directed[9] = '{48'h0, 1'b1, 1'b0, none};
    directed[10] = '{48'h7fff_ffff_ff00, 1'b1, 1'b0, none};
    directed[11] = '{48'hffff_ffff_ffff, 1'b1, 1'b0, none};
    directed[12] = '{48'h0000_0000_0001, 1'b0, 1'b0, none};
    directed[13] = '{48'h0000_0000_0001, 1'b0, 1'b0, none};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k])
      send_branch(directed[k].addr, directed[k].taken, directed[k].fixed, directed[k].want);

    write_threshold(0);
    no_stall = 1'b1;
    random_branches(60);
    no_stall = 1'b0;
    random_branches(140);

    write_threshold(8191);
    for (int n = 0; n < 140; n++) send_branch(48'h5, 1'b1, 1'b0, none);
    for (int n = 0; n < 140; n++) send_branch(48'h6, 1'b0, 1'b0, none);
    random_branches(150);

    write_threshold(4191);
    hold_rsp <= 1'b1;
    @(posedge clk);
    hold_rsp <= 1'b0;
    random_branches(200);

    write_threshold($urandom_range(1, 4190));
    random_branches(120);
    drain_requests();
    random_branches(120);

    write_threshold(75);
    random_branches(180);

    drain_requests();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- perceptron_branch_predictor.f -----
+incdir+src
src/pbp_pkg.sv
src/pbp_if.sv
src/pbp_ram.sv
src/pbp_front.sv
src/pbp_back.sv
src/perceptron_branch_predictor.sv
tb/tb_top.sv
